// File: hw/rtl/ray_triangle_closest_hit_top_macros.svh
// ----------------------------------------------------------------------------
// Ray/triangle closest-hit assertion macros
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_CLOSEST_HIT_TOP_MACROS_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RTCH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtch check failed");

// Next-cycle implication, disabled in reset.
`define RTCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtch check failed");

`endif

// File: hw/rtl/rtch_pkg.sv
// ----------------------------------------------------------------------------
// rtch_pkg
// Widths, register indexes and saturation helper for the closest-hit block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rtch_pkg;
    localparam int DATA_W = 32;
    localparam int TOL_W  = 16;
    localparam int DIST_W = 31;
    localparam int IDX_W  = 3;
    localparam int ACC_W  = 50;

    typedef logic signed [DATA_W-1:0] t_q16;

    localparam logic [IDX_W-1:0] REG_ORG_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORG_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_ORG_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIR_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_DIR_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_DIR_Z = 3'd5;
    localparam logic [IDX_W-1:0] REG_TOL   = 3'd6;

    localparam t_q16 Q_ONE   = 32'sh0001_0000;
    localparam t_q16 S32_MAX = 32'sh7FFF_FFFF;
    localparam t_q16 S32_MIN = -32'sh7FFF_FFFF - 32'sh1;

    // clamp a wide signed value to signed 32 bits
    function automatic t_q16 sat32(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(S32_MAX)) begin
            return S32_MAX;
        end else if (v < ACC_W'(S32_MIN)) begin
            return S32_MIN;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/ray_triangle_closest_hit_top.sv
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_top
// Moller-Trumbore closest-hit search of one ray over a triangle stream.
// ----------------------------------------------------------------------------
// Each triangle request is tested against the configured ray in signed
// Q16.16. The block takes one request at a time and holds o_in_stall high
// while it works: 24 products run through one 32x32 multiplier, each in an
// ST_MUL and an ST_ACC state, and the three quotients u, v, t run through a
// restoring divider at one quotient bit per cycle (48 bits, then an ST_QCHK
// check). A last triangle then waits in ST_EMIT until the output register is
// free and loads the result. A near-parallel triangle, a failed u test and a
// failed v test leave early and skip the remaining products and quotients.
// The divider sets the rate. A result request comes only on a triangle with
// last_triangle set; a result waits in the output register while the next
// triangle starts. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ray_triangle_closest_hit_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [rtch_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire [rtch_pkg::DATA_W-1:0]   i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire signed [rtch_pkg::DATA_W-1:0] i_vertex_a_x,
    input  wire signed [rtch_pkg::DATA_W-1:0] i_vertex_a_y,
    input  wire signed [rtch_pkg::DATA_W-1:0] i_vertex_a_z,
    input  wire signed [rtch_pkg::DATA_W-1:0] i_vertex_b_x,
    input  wire signed [rtch_pkg::DATA_W-1:0] i_vertex_b_y,
    input  wire signed [rtch_pkg::DATA_W-1:0] i_vertex_b_z,
    input  wire signed [rtch_pkg::DATA_W-1:0] i_vertex_c_x,
    input  wire signed [rtch_pkg::DATA_W-1:0] i_vertex_c_y,
    input  wire signed [rtch_pkg::DATA_W-1:0] i_vertex_c_z,
    input  wire                          i_last_triangle,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_any_hit,
    output logic [rtch_pkg::DIST_W-1:0]  o_closest_distance
);
    import rtch_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_QCHK = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    localparam logic [4:0] STEP_DET = 5'd8;
    localparam logic [4:0] STEP_U   = 5'd11;
    localparam logic [4:0] STEP_V   = 5'd20;
    localparam logic [4:0] STEP_T   = 5'd23;
    localparam logic [5:0] DIV_BITS = 6'd48;

    // configuration
    t_q16             r_org [3];
    t_q16             r_dir [3];
    logic [TOL_W-1:0] r_tol;

    // per-triangle working set
    logic [2:0]  r_state;
    logic [4:0]  r_step;
    t_q16        r_e1 [3];
    t_q16        r_e2 [3];
    t_q16        r_s  [3];
    t_q16        r_p  [3];
    t_q16        r_q  [3];
    t_q16        r_det;
    t_q16        r_u;
    t_q16        r_tval;
    logic        r_last;
    logic        r_hit;
    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [ACC_W-1:0]    r_acc;

    // divider
    logic [47:0] r_dq;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic        r_qneg;
    logic [5:0]  r_cnt;

    // mesh state and output register
    t_q16        r_best;
    logic        r_seen;
    logic        r_out_valid;
    logic        r_out_hit;
    logic [DIST_W-1:0] r_out_dist;

    // microcode decode
    t_q16 op_a, op_b;
    logic op_neg, op_start, op_end;

    always_comb begin
        op_a = '0; op_b = '0; op_neg = 1'b0; op_start = 1'b0; op_end = 1'b0;
        unique case (r_step)
            5'd0:  begin op_a = r_dir[1]; op_b = r_e2[2]; op_start = 1'b1; end
            5'd1:  begin op_a = r_dir[2]; op_b = r_e2[1]; op_neg = 1'b1; op_end = 1'b1; end
            5'd2:  begin op_a = r_dir[2]; op_b = r_e2[0]; op_start = 1'b1; end
            5'd3:  begin op_a = r_dir[0]; op_b = r_e2[2]; op_neg = 1'b1; op_end = 1'b1; end
            5'd4:  begin op_a = r_dir[0]; op_b = r_e2[1]; op_start = 1'b1; end
            5'd5:  begin op_a = r_dir[1]; op_b = r_e2[0]; op_neg = 1'b1; op_end = 1'b1; end
            5'd6:  begin op_a = r_e1[0]; op_b = r_p[0]; op_start = 1'b1; end
            5'd7:  begin op_a = r_e1[1]; op_b = r_p[1]; end
            5'd8:  begin op_a = r_e1[2]; op_b = r_p[2]; op_end = 1'b1; end
            5'd9:  begin op_a = r_s[0]; op_b = r_p[0]; op_start = 1'b1; end
            5'd10: begin op_a = r_s[1]; op_b = r_p[1]; end
            5'd11: begin op_a = r_s[2]; op_b = r_p[2]; op_end = 1'b1; end
            5'd12: begin op_a = r_s[1]; op_b = r_e1[2]; op_start = 1'b1; end
            5'd13: begin op_a = r_s[2]; op_b = r_e1[1]; op_neg = 1'b1; op_end = 1'b1; end
            5'd14: begin op_a = r_s[2]; op_b = r_e1[0]; op_start = 1'b1; end
            5'd15: begin op_a = r_s[0]; op_b = r_e1[2]; op_neg = 1'b1; op_end = 1'b1; end
            5'd16: begin op_a = r_s[0]; op_b = r_e1[1]; op_start = 1'b1; end
            5'd17: begin op_a = r_s[1]; op_b = r_e1[0]; op_neg = 1'b1; op_end = 1'b1; end
            5'd18: begin op_a = r_dir[0]; op_b = r_q[0]; op_start = 1'b1; end
            5'd19: begin op_a = r_dir[1]; op_b = r_q[1]; end
            5'd20: begin op_a = r_dir[2]; op_b = r_q[2]; op_end = 1'b1; end
            5'd21: begin op_a = r_e2[0]; op_b = r_q[0]; op_start = 1'b1; end
            5'd22: begin op_a = r_e2[1]; op_b = r_q[1]; end
            5'd23: begin op_a = r_e2[2]; op_b = r_q[2]; op_end = 1'b1; end
            default: begin end
        endcase
    end

    // accumulate: floor of product / 2^16, signed
    logic signed [47:0]      mulq;
    logic signed [ACC_W-1:0] n_acc;
    t_q16                    acc_sat;
    assign mulq    = r_prod[63:16];
    assign n_acc   = (op_start ? '0 : r_acc)
                   + (op_neg ? -ACC_W'(mulq) : ACC_W'(mulq));
    assign acc_sat = sat32(n_acc);

    // tolerance bounds
    logic signed [33:0] tol_s, neg_tol, hi_bound;
    assign tol_s    = 34'(r_tol);
    assign neg_tol  = -tol_s;
    assign hi_bound = 34'(Q_ONE) + tol_s;

    logic signed [33:0] det_w;
    logic               det_rej;
    assign det_w   = 34'(acc_sat);
    assign det_rej = (acc_sat == '0) || ((det_w > neg_tol) && (det_w < tol_s));

    // divider step
    logic [32:0] rem_sh;
    logic        div_ge;
    assign rem_sh = {r_rem, r_dq[47]};
    assign div_ge = rem_sh >= {1'b0, r_dvs};

    // quotient finish
    logic signed [ACC_W-1:0] q_s;
    t_q16                    q_sat;
    logic signed [33:0]      q_w;
    logic signed [33:0]      uv_sum;
    assign q_s    = r_qneg ? -ACC_W'({1'b0, r_dq}) : ACC_W'({1'b0, r_dq});
    assign q_sat  = sat32(q_s);
    assign q_w    = 34'(q_sat);
    assign uv_sum = 34'(r_u) + q_w;

    // numerator magnitude and sign for divider setup
    logic [31:0] num_mag, det_mag;
    assign num_mag = acc_sat[31] ? 32'(-33'(acc_sat)) : 32'(acc_sat);
    assign det_mag = r_det[31] ? 32'(-33'(r_det)) : 32'(r_det);

    logic in_acc, out_free;
    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    function automatic t_q16 sub_sat(input t_q16 a, input t_q16 b);
        return sat32(ACC_W'(a) - ACC_W'(b));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0; r_org[1] <= '0; r_org[2] <= '0;
            r_dir[0] <= '0; r_dir[1] <= '0; r_dir[2] <= Q_ONE;
            r_tol       <= TOL_W'(7);
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_best      <= S32_MAX;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration write
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ORG_X: r_org[0] <= i_cfg_data;
                    REG_ORG_Y: r_org[1] <= i_cfg_data;
                    REG_ORG_Z: r_org[2] <= i_cfg_data;
                    REG_DIR_X: r_dir[0] <= i_cfg_data;
                    REG_DIR_Y: r_dir[1] <= i_cfg_data;
                    REG_DIR_Z: r_dir[2] <= i_cfg_data;
                    REG_TOL:   r_tol    <= i_cfg_data[TOL_W-1:0];
                    default: begin end
                endcase
            end

            // drop the result once taken, unless a new one loads now
            if (r_out_valid && !i_out_stall && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        // form edges and origin offset
                        r_e1[0] <= sub_sat(i_vertex_b_x, i_vertex_a_x);
                        r_e1[1] <= sub_sat(i_vertex_b_y, i_vertex_a_y);
                        r_e1[2] <= sub_sat(i_vertex_b_z, i_vertex_a_z);
                        r_e2[0] <= sub_sat(i_vertex_c_x, i_vertex_a_x);
                        r_e2[1] <= sub_sat(i_vertex_c_y, i_vertex_a_y);
                        r_e2[2] <= sub_sat(i_vertex_c_z, i_vertex_a_z);
                        r_s[0]  <= sub_sat(r_org[0], i_vertex_a_x);
                        r_s[1]  <= sub_sat(r_org[1], i_vertex_a_y);
                        r_s[2]  <= sub_sat(r_org[2], i_vertex_a_z);
                        r_last  <= i_last_triangle;
                        r_hit   <= 1'b0;
                        r_step  <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= op_a * op_b;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_acc <= n_acc;
                    if (!op_end) begin
                        r_step  <= r_step + 5'd1;
                        r_state <= ST_MUL;
                    end else begin
                        unique case (r_step)
                            5'd1:  r_p[0] <= acc_sat;
                            5'd3:  r_p[1] <= acc_sat;
                            5'd5:  r_p[2] <= acc_sat;
                            5'd13: r_q[0] <= acc_sat;
                            5'd15: r_q[1] <= acc_sat;
                            5'd17: r_q[2] <= acc_sat;
                            STEP_DET: r_det <= acc_sat;
                            default: begin end
                        endcase
                        if (r_step == STEP_DET) begin
                            r_step  <= r_step + 5'd1;
                            r_state <= det_rej ? ST_FIN : ST_MUL;
                        end else if (r_step == STEP_U || r_step == STEP_V
                                     || r_step == STEP_T) begin
                            // start the divider on |num| * 2^16 / |det|
                            r_dq    <= {num_mag, 16'h0000};
                            r_rem   <= '0;
                            r_dvs   <= det_mag;
                            r_qneg  <= acc_sat[31] ^ r_det[31];
                            r_cnt   <= DIV_BITS;
                            r_state <= ST_DIV;
                        end else begin
                            r_step  <= r_step + 5'd1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem <= div_ge ? 32'(rem_sh - {1'b0, r_dvs}) : rem_sh[31:0];
                    r_dq  <= {r_dq[46:0], div_ge};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= ST_QCHK;
                    end
                end
                ST_QCHK: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == STEP_U) begin
                        r_u     <= q_sat;
                        r_state <= ((q_w < neg_tol) || (q_w > hi_bound)) ? ST_FIN : ST_MUL;
                    end else if (r_step == STEP_V) begin
                        r_state <= ((q_w < neg_tol) || (uv_sum > hi_bound))
                                   ? ST_FIN : ST_MUL;
                    end else begin
                        r_hit   <= q_w > tol_s;
                        r_tval  <= q_sat;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (r_hit) begin
                        if (!r_seen || (r_tval < r_best)) begin
                            r_best <= r_tval;
                        end
                        r_seen <= 1'b1;
                    end
                    r_state <= r_last ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_seen;
                        r_out_dist  <= r_seen ? r_best[DIST_W-1:0] : '0;
                        r_best      <= S32_MAX;
                        r_seen      <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall         = (r_state != ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_any_hit          = r_out_hit;
    assign o_closest_distance = r_out_dist;
endmodule
`default_nettype wire

// File: hw/rtl/rtch_checker.sv
// ----------------------------------------------------------------------------
// rtch_checker
// Port-level checks for the closest-hit block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ray_triangle_closest_hit_top_macros.svh"
module rtch_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          o_in_stall,
    input wire                          o_out_valid,
    input wire                          i_out_stall,
    input wire                          o_any_hit,
    input wire [rtch_pkg::DIST_W-1:0]   o_closest_distance
);
    import rtch_pkg::*;

    logic              req_taken;
    logic              out_held;
    logic              out_miss;
    logic [DIST_W:0]   out_word;
    assign req_taken = i_in_valid && !o_in_stall;
    assign out_held  = o_out_valid && i_out_stall;
    assign out_miss  = o_out_valid && !o_any_hit;
    assign out_word  = {o_any_hit, o_closest_distance};

    // a missed triangle set reports zero distance
    `RTCH_ASSERT_NOW(a_nohit_zero, i_clk, i_rst_n, out_miss, o_closest_distance == '0)
    // an accepted triangle keeps the block busy next cycle
    `RTCH_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, req_taken, o_in_stall)
    // a result never appears in the cycle right after a request is taken
    `RTCH_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, req_taken && !o_out_valid, !o_out_valid)
    // a stalled result holds
    `RTCH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_word))
endmodule

bind ray_triangle_closest_hit_top rtch_checker u_rtch_checker (.*);
`default_nettype wire

// File: tb/ray_triangle_closest_hit_top_test.sv
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_top_test
// Streams triangle meshes against several ray settings and checks each
// closest-hit result against a fixed-point Moller-Trumbore predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ray_triangle_closest_hit_top_test;
    import rtch_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 400;

    typedef struct {
        logic signed [31:0] v[9];
        logic               last;
    } t_tri_req;

    typedef struct {
        logic        any_hit;
        logic [30:0] distance;
    } t_hit_res;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] vtx[9] = '{default: '0};
    logic last_tri = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic any_hit;
    logic [30:0] closest_distance;

    // prediction state
    longint ray_org[3];
    longint ray_dir[3];
    longint tol;
    longint best_dist;
    bit     hit_flag;

    t_tri_req pending_tris[$];
    t_hit_res expected_hits[$];
    int mismatches = 0;
    int accepted_tris = 0;
    int checked_hits = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    bit driver_on = 1'b0;
    bit hold_off = 1'b0;

    always #5 clk = ~clk;

    ray_triangle_closest_hit_top u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_vertex_a_x(vtx[0]), .i_vertex_a_y(vtx[1]), .i_vertex_a_z(vtx[2]),
        .i_vertex_b_x(vtx[3]), .i_vertex_b_y(vtx[4]), .i_vertex_b_z(vtx[5]),
        .i_vertex_c_x(vtx[6]), .i_vertex_c_y(vtx[7]), .i_vertex_c_z(vtx[8]),
        .i_last_triangle(last_tri),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_any_hit(any_hit), .o_closest_distance(closest_distance)
    );

    // ------------------------------------------------------------------
    // fixed-point helpers, 64-bit signed throughout
    // ------------------------------------------------------------------
    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // product then floor by 2^16 (arithmetic shift)
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic longint qdot(longint a[3], longint b[3]);
        return clamp32(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]));
    endfunction

    function automatic void qcross(input longint a[3], input longint b[3],
                                   output longint r[3]);
        r[0] = clamp32(qmul(a[1], b[2]) - qmul(a[2], b[1]));
        r[1] = clamp32(qmul(a[2], b[0]) - qmul(a[0], b[2]));
        r[2] = clamp32(qmul(a[0], b[1]) - qmul(a[1], b[0]));
    endfunction

    // SV division truncates toward zero, as required
    function automatic longint qquot(longint n, longint det);
        return clamp32((n * 65536) / det);
    endfunction

    // Moller-Trumbore hit test; returns 1 with the distance on a hit
    function automatic bit hit_distance(t_tri_req r, output longint t);
        longint a[3], b[3], c[3], e1[3], e2[3], p[3], s[3], q[3];
        longint det, u, v;
        t = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = r.v[i];
            b[i] = r.v[3 + i];
            c[i] = r.v[6 + i];
        end
        for (int i = 0; i < 3; i++) begin
            e1[i] = clamp32(b[i] - a[i]);
            e2[i] = clamp32(c[i] - a[i]);
            s[i]  = clamp32(ray_org[i] - a[i]);
        end
        qcross(ray_dir, e2, p);
        det = qdot(e1, p);
        if (det == 0 || (det > -tol && det < tol)) return 1'b0;
        u = qquot(qdot(s, p), det);
        if (u < -tol || u > 65536 + tol) return 1'b0;
        qcross(s, e1, q);
        v = qquot(qdot(ray_dir, q), det);
        if (v < -tol || (u + v) > 65536 + tol) return 1'b0;
        t = qquot(qdot(e2, q), det);
        return t > tol;
    endfunction

    // advance the predictor by one accepted triangle
    task automatic predict_closest_hit(t_tri_req r);
        longint t;
        t_hit_res h;
        if (hit_distance(r, t)) begin
            if (!hit_flag || t < best_dist) best_dist = t;
            hit_flag = 1'b1;
        end
        if (r.last) begin
            h.any_hit = hit_flag;
            h.distance = hit_flag ? best_dist[30:0] : '0;
            expected_hits.push_back(h);
            best_dist = 64'sd2147483647;
            hit_flag = 1'b0;
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // driver: bursts with random gaps, fed from pending_tris
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_tri_req r;
        if (in_valid && !in_stall) begin
            predict_closest_hit(pending_tris.pop_front());
            accepted_tris++;
        end
        // hold a stalled request; otherwise choose the next one
        if (!(in_valid && in_stall)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (driver_on && !hold_off && pending_tris.size() > 0 &&
                         !(in_valid && !in_stall && pending_tris.size() == 0)) begin
                r = pending_tris[0];
                for (int i = 0; i < 9; i++) vtx[i] <= r.v[i];
                last_tri <= r.last;
                in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: check results, drive the receiver stall pattern
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_hit_res h;
        if (out_valid && !out_stall) begin
            checked_hits++;
            if (expected_hits.size() == 0) begin
                report_mismatch("unexpected result", any_hit, 0);
            end else begin
                h = expected_hits.pop_front();
                if (any_hit !== h.any_hit) report_mismatch("any_hit", any_hit, h.any_hit);
                if (closest_distance !== h.distance)
                    report_mismatch("closest_distance", closest_distance, h.distance);
            end
        end
        // stretches of no stall alternate with random stalling
        if (accepted_tris % 200 < 60) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 3) == 0);
    end

    // watchdog: count cycles with no handshake
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !driver_on)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("ray_triangle_closest_hit_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
            default: return $signed($urandom_range(0, 2 * 65536)) - 65536;
        endcase
    endfunction

    // a triangle the ray is likely to cross at z=dist, around the ray axis
    function automatic t_tri_req aimed_tri(bit last);
        t_tri_req r;
        longint zc, k;
        zc = ray_org[2] + $urandom_range(0, 40 * 65536);
        k = $urandom_range(1, 8) * 65536;
        r.v[0] = clamp32(ray_org[0] - k);  r.v[1] = clamp32(ray_org[1] - k);
        r.v[2] = clamp32(zc);
        r.v[3] = clamp32(ray_org[0] + k);  r.v[4] = clamp32(ray_org[1] - k);
        r.v[5] = clamp32(zc + $signed($urandom_range(0, 65536)) - 32768);
        r.v[6] = clamp32(ray_org[0]);      r.v[7] = clamp32(ray_org[1] + k);
        r.v[8] = clamp32(zc);
        if ($urandom_range(0, 5) == 0) r.v[$urandom_range(0, 8)] = rand_coord(1);
        r.last = last;
        return r;
    endfunction

    function automatic t_tri_req random_tri(bit last);
        t_tri_req r;
        int mode;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < 9; i++) r.v[i] = rand_coord(mode);
        r.last = last;
        return r;
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx <= REG_ORG_Z) ray_org[idx] = longint'($signed(val));
        else if (idx <= REG_DIR_Z) ray_dir[idx - REG_DIR_X] = longint'($signed(val));
        else tol = val[15:0];
    endtask

    // wait for the block to drain, then for any non-last triangle in flight
    task automatic wait_idle();
        wait (pending_tris.size() == 0 && !in_valid);
        wait (expected_hits.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_ray(longint o0, longint o1, longint o2,
                           longint d0, longint d1, longint d2, longint t);
        write_reg(REG_ORG_X, o0[31:0]);
        write_reg(REG_ORG_Y, o1[31:0]);
        write_reg(REG_ORG_Z, o2[31:0]);
        write_reg(REG_DIR_X, d0[31:0]);
        write_reg(REG_DIR_Y, d1[31:0]);
        write_reg(REG_DIR_Z, d2[31:0]);
        write_reg(REG_TOL, t[31:0]);
    endtask

    task automatic push_mesh(int n, int aimed_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < aimed_pct)
                pending_tris.push_back(aimed_tri(i == n - 1));
            else
                pending_tris.push_back(random_tri(i == n - 1));
        end
    endtask

    initial begin
        t_tri_req r;
        int mesh_cnt;
        ray_org = '{0, 0, 0};
        ray_dir = '{0, 0, 65536};
        tol = 7;
        best_dist = 64'sd2147483647;
        hit_flag = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        driver_on = 1'b1;

        // directed: reset ray, hit unit triangle, then extremes
        r.v = '{-65536, -65536, 5 * 65536, 65536, -65536, 5 * 65536,
                0, 65536, 5 * 65536};
        r.last = 1'b0;
        pending_tris.push_back(r);
        // nearer one: replaces best
        r.v = '{-65536, -65536, 2 * 65536, 65536, -65536, 2 * 65536,
                0, 65536, 2 * 65536};
        pending_tris.push_back(r);
        // same distance again: tie keeps the first
        pending_tris.push_back(r);
        // degenerate (zero area): det zero
        r.v = '{0, 0, 65536, 0, 0, 65536, 0, 0, 65536};
        pending_tris.push_back(r);
        // triangle behind the origin: t not above tolerance
        r.v = '{-65536, -65536, -3 * 65536, 65536, -65536, -3 * 65536,
                0, 65536, -3 * 65536};
        pending_tris.push_back(r);
        // ray misses to the side: u out of bounds
        r.v = '{4 * 65536, -65536, 65536, 6 * 65536, -65536, 65536,
                5 * 65536, 65536, 65536};
        r.last = 1'b1;
        pending_tris.push_back(r);
        // mesh with no hit at all: parallel triangle, last
        r.v = '{0, 0, 65536, 65536, 0, 65536, 0, 0, 2 * 65536};
        pending_tris.push_back(r);
        // extremes of every field, each a single-triangle mesh
        r.v = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0};
        pending_tris.push_back(r);
        for (int i = 0; i < 9; i++) r.v[i] = 32'sh80000000;
        pending_tris.push_back(r);
        for (int i = 0; i < 9; i++) r.v[i] = -1;
        pending_tris.push_back(r);
        // huge far triangle: edges and dot products saturate
        r.v = '{32'sh80000000, 32'sh80000000, 32'sh7FFF0000, 32'sh7FFFFFFF,
                32'sh80000000, 32'sh7FFF0000, 0, 32'sh7FFFFFFF, 32'sh7FFF0000};
        pending_tris.push_back(r);
        wait_idle();

        // tolerance zero and maximum, with extreme ray settings
        set_ray(0, 0, 0, 0, 0, 65536, 0);
        pending_tris.push_back(aimed_tri(1'b0));
        r.v = '{0, 0, 65536, 0, 0, 65536, 0, 0, 65536};
        r.last = 1'b1;
        pending_tris.push_back(r);
        wait_idle();
        set_ray(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 65535);
        push_mesh(3, 50);
        push_mesh(1, 0);
        wait_idle();

        // random: phases of ray settings, mostly aimed meshes
        mesh_cnt = 0;
        while (accepted_tris + pending_tris.size() < 1050) begin
            if (mesh_cnt % 25 == 0) begin
                wait_idle();
                case ($urandom_range(0, 3))
                    0: set_ray(0, 0, 0, 0, 0, 65536, 7);
                    1: set_ray($urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom_range(0, 65535));
                    2: set_ray($signed($urandom_range(0, 8 * 65536)) - 4 * 65536,
                               $signed($urandom_range(0, 8 * 65536)) - 4 * 65536,
                               -(20 * 65536), 0, 0, 65536, $urandom_range(0, 300));
                    default: set_ray(65536, -65536, 0,
                                     $signed($urandom_range(0, 4096)) - 2048,
                                     $signed($urandom_range(0, 4096)) - 2048,
                                     65536, $urandom_range(0, 20));
                endcase
            end
            // pause the sender until every result is back, once a while
            if (mesh_cnt % 40 == 20) begin
                hold_off = 1'b1;
                wait (expected_hits.size() == 0 && !in_valid);
                hold_off = 1'b0;
            end
            push_mesh($urandom_range(1, 6), 80);
            mesh_cnt++;
            wait (pending_tris.size() < 8);
        end
        wait_idle();
        $display("covered %0d triangles, %0d closest-hit results over %0d meshes",
                 accepted_tris, checked_hits, mesh_cnt);
        if (mismatches == 0) begin
            $display("ray_triangle_closest_hit_top: match");
        end else begin
            $display("ray_triangle_closest_hit_top: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
